// ----- hdl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg - shared types and constants for the elevator stop scheduler
// Holds the floor count, derived widths, event kinds and travel status codes.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Number of floors served; one mask bit per floor
  localparam int FLOORS   = 16;
  localparam int FI_W     = $clog2(FLOORS);
  localparam int LEVEL_W  = 5;
  localparam int CUR_W    = 5;
  localparam int STATUS_W = 2;
  localparam int OPCODE_W = 2;

  // Opcodes on the input channel
  localparam logic [OPCODE_W-1:0] OP_HALL  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CAB   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_OPEN  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLOSE = 2'd3;

  // Travel status codes
  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOWN = 2'd2;

  // Event kinds after classification
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_HALL_UP = 3'd0;
  localparam kind_t KIND_HALL_DN = 3'd1;
  localparam kind_t KIND_CAB     = 3'd2;
  localparam kind_t KIND_OPEN    = 3'd3;
  localparam kind_t KIND_CLOSE   = 3'd4;
  localparam kind_t KIND_BAD     = 3'd5;

  // Classified event word passed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [FI_W-1:0]   idx;
  } evt_t;

endpackage

// ----- hdl/esc_front.sv -----
// ----------------------------------------------------------------------------
// esc_front - event decode stage
// Registers each incoming word, checks the floor and turns it into an event.
// ----------------------------------------------------------------------------
module esc_front
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [LEVEL_W-1:0]  in_floor_level,
  input  logic                in_call_down,
  output logic                evt_valid,
  input  logic                evt_full,
  output evt_t                evt
);

  logic  front_valid_r, front_valid_nxt;
  evt_t  evt_r, evt_nxt;
  logic  accept;
  logic  level_ok;

  assign in_stall = front_valid_r && evt_full;
  assign accept   = in_valid && !in_stall;
  assign level_ok = (in_floor_level != '0) && (in_floor_level <= LEVEL_W'(FLOORS));

  always_comb begin
    evt_nxt.idx = FI_W'(in_floor_level - LEVEL_W'(1));
    unique case (in_opcode)
      OP_HALL: begin
        if (!level_ok) evt_nxt.kind = KIND_BAD;
        else if (in_call_down) evt_nxt.kind = KIND_HALL_DN;
        else evt_nxt.kind = KIND_HALL_UP;
      end
      OP_CAB:   evt_nxt.kind = level_ok ? KIND_CAB : KIND_BAD;
      OP_OPEN:  evt_nxt.kind = KIND_OPEN;
      OP_CLOSE: evt_nxt.kind = KIND_CLOSE;
      default:  evt_nxt.kind = KIND_BAD;
    endcase
  end

  // Hold the word while the queue is full
  assign front_valid_nxt = accept || (front_valid_r && evt_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt_r <= evt_nxt;
    end
  end

  assign evt_valid = front_valid_r;
  assign evt       = evt_r;

endmodule

// ----- hdl/esc_fifo.sv -----
// ----------------------------------------------------------------------------
// esc_fifo - two-entry event queue
// Decouples decode from execution so either side may stall.
// ----------------------------------------------------------------------------
module esc_fifo
  import esc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic full,
  input  evt_t push_evt,
  output logic pop_valid,
  input  logic pop,
  output evt_t pop_evt
);

  evt_t       mem [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_evt   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    else if (do_pop && !do_push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

endmodule

// ----- hdl/esc_back.sv -----
// ----------------------------------------------------------------------------
// esc_back - event execution stage
// Applies one event per cycle, unless the output is stalled, to the stop
// masks, floor and status, and registers the new state as the output word.
// ----------------------------------------------------------------------------
module esc_back
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                evt_valid,
  output logic                evt_pop,
  input  evt_t                evt,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CUR_W-1:0]    out_current_floor,
  output logic [STATUS_W-1:0] out_travel_status,
  output logic [FLOORS-1:0]   out_up_pending,
  output logic [FLOORS-1:0]   out_down_pending,
  output logic                out_stop_served,
  output logic                out_level_error
);

  localparam logic [FI_W:0] FLOORS_S = (FI_W+1)'(FLOORS);

  logic [FLOORS-1:0]   up_r, up_nxt, down_r, down_nxt;
  logic [FI_W-1:0]     fi_r, fi_nxt;
  logic [STATUS_W-1:0] dir_r, dir_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                served, err;
  logic [FLOORS-1:0]   bit_sel;

  logic [2*FLOORS-1:0] up_dbl, down_dbl, up_shift, down_shift;
  logic [FLOORS-1:0]   up_win, down_win;
  logic [FI_W-1:0]     up_pos, down_pos;
  logic                up_hit, down_hit;
  logic [FI_W:0]       up_sum, down_sum;
  logic [FI_W-1:0]     up_f, down_f;

  assign evt_pop = evt_valid && (!out_valid_r || !out_stall);
  assign bit_sel = FLOORS'(1) << evt.idx;

  // Rotate masks so the search starts at the current floor
  assign up_dbl     = {up_r, up_r};
  assign down_dbl   = {down_r, down_r};
  assign up_shift   = up_dbl >> fi_r;
  assign down_shift = (down_dbl >> 1) >> fi_r;
  assign up_win     = up_shift[FLOORS-1:0];
  assign down_win   = down_shift[FLOORS-1:0];

  // Up: lowest set bit of the window; down: highest set bit
  always_comb begin
    up_pos = '0;
    up_hit = 1'b0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (up_win[i]) begin
        up_pos = FI_W'(i);
        up_hit = 1'b1;
      end
    end
  end

  always_comb begin
    down_pos = '0;
    down_hit = 1'b0;
    for (int i = 0; i < FLOORS; i++) begin
      if (down_win[i]) begin
        down_pos = FI_W'(i);
        down_hit = 1'b1;
      end
    end
  end

  always_comb begin
    up_sum   = {1'b0, fi_r} + {1'b0, up_pos};
    down_sum = {1'b0, fi_r} + {1'b0, down_pos} + (FI_W+1)'(1);
    up_f     = (up_sum >= FLOORS_S) ? FI_W'(up_sum - FLOORS_S) : FI_W'(up_sum);
    down_f   = (down_sum >= FLOORS_S) ? FI_W'(down_sum - FLOORS_S) : FI_W'(down_sum);
  end

  always_comb begin
    up_nxt   = up_r;
    down_nxt = down_r;
    fi_nxt   = fi_r;
    dir_nxt  = dir_r;
    served   = 1'b0;
    err      = 1'b0;
    unique case (evt.kind)
      KIND_HALL_UP: begin
        up_nxt = up_r | bit_sel;
        if (down_r == '0) dir_nxt = ST_UP;
      end
      KIND_HALL_DN: begin
        down_nxt = down_r | bit_sel;
        if (up_r == '0) dir_nxt = ST_DOWN;
      end
      KIND_CAB: begin
        if (dir_r == ST_UP && evt.idx >= fi_r) up_nxt = up_r | bit_sel;
        else if (dir_r == ST_DOWN && evt.idx <= fi_r) down_nxt = down_r | bit_sel;
      end
      KIND_OPEN: begin
        if (dir_r == ST_UP && up_hit) begin
          fi_nxt = up_f;
          up_nxt = up_r & ~(FLOORS'(1) << up_f);
          served = 1'b1;
        end else if (dir_r == ST_DOWN && down_hit) begin
          fi_nxt   = down_f;
          down_nxt = down_r & ~(FLOORS'(1) << down_f);
          served   = 1'b1;
        end
      end
      KIND_CLOSE: begin
        priority if (dir_r == ST_IDLE) begin
          if (down_r == '0) dir_nxt = ST_UP;
          else if (up_r == '0) dir_nxt = ST_DOWN;
        end else if (dir_r == ST_UP) begin
          if (up_r == '0) dir_nxt = (down_r == '0) ? ST_IDLE : ST_DOWN;
        end else begin
          if (down_r == '0) dir_nxt = (up_r == '0) ? ST_IDLE : ST_UP;
        end
      end
      default: err = 1'b1;
    endcase
  end

  assign out_valid_nxt = evt_pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r        <= '0;
      down_r      <= '0;
      fi_r        <= '0;
      dir_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (evt_pop) begin
        up_r   <= up_nxt;
        down_r <= down_nxt;
        fi_r   <= fi_nxt;
        dir_r  <= dir_nxt;
      end
    end
  end

  // Output word shows the state after the event
  always_ff @(posedge clk) begin
    if (evt_pop) begin
      out_current_floor <= CUR_W'(fi_nxt) + CUR_W'(1);
      out_travel_status <= dir_nxt;
      out_up_pending    <= up_nxt;
      out_down_pending  <= down_nxt;
      out_stop_served   <= served;
      out_level_error   <= err;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/elevator_stop_scheduler.sv -----
// ----------------------------------------------------------------------------
// elevator_stop_scheduler - elevator stop scheduling engine
// Keeps pending up and down stops, the car floor and travel status, and
// returns one state word for every event word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one event word per handshake, taken at a rising
//   edge with in_valid high and in_stall low. Opcodes: hall call, cab button,
//   door open, door close. A bad floor on a call or button is ignored and
//   flagged with out_level_error.
//   Output channel (out_*): one word per event, in order, holding the floor,
//   travel status and both stop masks after the event, plus the served and
//   error flags. Taken when out_valid is high and out_stall is low.
//   Throughput: one word per cycle while out_stall is low. Path: decode
//   register, queue, output register; the door open search is a
//   combinational rotating priority encoder over the masks.
//   Receiver stall: the output word holds; the two-entry queue fills, then
//   the decode register holds and in_stall rises.
//   Reset (rst_n low, synchronous): masks clear, car at floor 1, idle, empty.
// ----------------------------------------------------------------------------
module elevator_stop_scheduler
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [LEVEL_W-1:0]  in_floor_level,
  input  logic                in_call_down,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CUR_W-1:0]    out_current_floor,
  output logic [STATUS_W-1:0] out_travel_status,
  output logic [FLOORS-1:0]   out_up_pending,
  output logic [FLOORS-1:0]   out_down_pending,
  output logic                out_stop_served,
  output logic                out_level_error
);

  // Front to queue
  logic front_valid;
  logic queue_full;
  evt_t front_evt;

  // Queue to back
  logic queue_valid;
  logic queue_pop;
  evt_t queue_evt;

  // Decode and range-check incoming words
  esc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_floor_level (in_floor_level),
    .in_call_down   (in_call_down),
    .evt_valid      (front_valid),
    .evt_full       (queue_full),
    .evt            (front_evt)
  );

  // Buffer events so decode keeps going while the output is held
  esc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .full       (queue_full),
    .push_evt   (front_evt),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_evt    (queue_evt)
  );

  // Execute events against the scheduler state
  esc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .evt_valid         (queue_valid),
    .evt_pop           (queue_pop),
    .evt               (queue_evt),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_floor (out_current_floor),
    .out_travel_status (out_travel_status),
    .out_up_pending    (out_up_pending),
    .out_down_pending  (out_down_pending),
    .out_stop_served   (out_stop_served),
    .out_level_error   (out_level_error)
  );

endmodule
